// ===== rtl/abtt_pkg.sv =====
package abtt_pkg;

  // Result item widths fixed by the port list
  localparam int SlotBits = 6;
  localparam int OutBits  = 32;

  // Most result beats one search may return
  localparam int MaxRes = 63;

  typedef enum logic [2:0] {
    REQ_INSERT        = 3'd0,
    REQ_DELETE        = 3'd1,
    REQ_FIND_PARENT   = 3'd2,
    REQ_FIND_CHILDREN = 3'd3,
    REQ_FIND_INDEX    = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_NOT_FOUND    = 3'd1,
    STAT_OCCUPIED     = 3'd2,
    STAT_PARENT_EMPTY = 3'd3,
    STAT_OUT_OF_RANGE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PAR_DATA,
    ST_KID_LEFT,
    ST_KID_RIGHT,
    ST_DEL_FIND,
    ST_DEL_WR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    status_e                     status;
    logic [SlotBits-1:0]         node_slot;
    logic [OutBits-1:0]          parent_value;
    logic                        parent_present;
    logic [OutBits-1:0]          left_value;
    logic                        left_present;
    logic [OutBits-1:0]          right_value;
    logic                        right_present;
  } item_t;

  // Result item with only status and slot filled in
  function automatic item_t plain_item(status_e st, logic [SlotBits-1:0] slot);
    item_t it;
    it                = '0;
    it.status         = st;
    it.node_slot      = slot;
    return it;
  endfunction

endpackage

// ===== rtl/abtt_ram.sv =====
module abtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/array_binary_tree_table_unit.sv =====
// Insert checks the target and writes it in the insert state, then hands its beat over.
// Searches and delete walk the table slot by slot, skipping empty slots and comparing
// occupied ones; a find parent match fetches the parent, a find children match the left and
// then the right child; delete of an inner node pulls from the highest occupied odd slot.
// Throughput: one request at a time, taken once the final beat is in the output register.
// Reset: asynchronous, active low; every valid bit clears at once, values stay undefined.
module array_binary_tree_table_unit #(
  parameter int TABLE_SIZE = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] key_value_i,
  input  logic [5:0]         parent_slot_i,
  input  logic               child_side_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [5:0]         node_slot_o,
  output logic signed [31:0] parent_value_o,
  output logic               parent_present_o,
  output logic signed [31:0] left_value_o,
  output logic               left_present_o,
  output logic signed [31:0] right_value_o,
  output logic               right_present_o,
  output logic               last_result_o
);

  localparam int IW    = $clog2(TABLE_SIZE);
  localparam int VW    = VALUE_BITS;
  localparam int OW    = abtt_pkg::OutBits;
  localparam int SW    = abtt_pkg::SlotBits;
  localparam int SLast = ((TABLE_SIZE - 1) % 2 == 1) ? TABLE_SIZE - 1 : TABLE_SIZE - 2;

  abtt_pkg::state_e state_q, state_d;
  abtt_pkg::req_e   req_q;

  logic [VW-1:0]         key_q;
  logic [5:0]            pslot_q;
  logic                  side_q;
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         sidx_q, sidx_d;
  logic [SW-1:0]         n_q, n_d;
  logic [TABLE_SIZE-1:0] valid_q;
  abtt_pkg::item_t       pend_q, pend_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [OW-1:0]         lval_q, lval_d;
  abtt_pkg::item_t       out_item_q, out_item_d;
  logic                  out_last_q, out_last_d;
  logic                  out_valid_q;
  logic                  out_load;
  logic                  out_free;
  logic                  in_accept;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [VW-1:0]         ram_wdata;
  logic [IW-1:0]         ram_raddr;
  logic [VW-1:0]         ram_rdata;

  logic                  vset;
  logic                  vclr;
  logic [IW-1:0]         vset_idx;
  logic [IW-1:0]         vclr_idx;

  logic [IW:0]           left_w;
  logic [IW:0]           right_w;
  logic                  left_occ;
  logic                  right_occ;
  logic [IW-1:0]         up_idx;
  logic                  scan_end;
  logic                  p_in_range;
  logic [IW-1:0]         p_idx;
  logic [IW:0]           c_w;
  logic                  key_hit;
  logic                  can_push;
  abtt_pkg::item_t       new_item;

  assign in_stall_o = (state_q != abtt_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign can_push   = !pend_valid_q || out_free;

  // slot neighbours of the scan position
  assign left_w    = {idx_q, 1'b0};
  assign right_w   = {idx_q, 1'b1};
  assign left_occ  = (left_w < (IW + 1)'(TABLE_SIZE)) && valid_q[left_w[IW-1:0]];
  assign right_occ = (right_w < (IW + 1)'(TABLE_SIZE)) && valid_q[right_w[IW-1:0]];
  assign up_idx    = idx_q >> 1;
  assign scan_end  = (idx_q == IW'(TABLE_SIZE - 1));
  assign key_hit   = (ram_rdata == key_q);

  // insert target
  assign p_in_range = ({26'd0, pslot_q} < 32'(TABLE_SIZE));
  assign p_idx      = IW'(pslot_q);
  assign c_w        = {p_idx, side_q};

  abtt_ram #(
    .WIDTH(VW),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sequencer: next state, memory access and result handling
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    sidx_d       = sidx_q;
    n_d          = n_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    lval_d       = lval_q;
    out_load     = 1'b0;
    out_item_d   = pend_q;
    out_last_d   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = key_q;
    ram_raddr    = idx_q;
    vset         = 1'b0;
    vset_idx     = idx_q;
    vclr         = 1'b0;
    vclr_idx     = idx_q;
    new_item     = abtt_pkg::plain_item(abtt_pkg::STAT_OK, SW'(idx_q));

    unique case (state_q)
      abtt_pkg::ST_IDLE: begin
        idx_d = IW'(1);
        n_d   = '0;
        if (in_accept) begin
          unique case (abtt_pkg::req_e'(req_type_i))
            abtt_pkg::REQ_INSERT:        state_d = abtt_pkg::ST_INSERT;
            abtt_pkg::REQ_DELETE,
            abtt_pkg::REQ_FIND_PARENT,
            abtt_pkg::REQ_FIND_CHILDREN,
            abtt_pkg::REQ_FIND_INDEX:    state_d = abtt_pkg::ST_SCAN_RD;
            default:                     state_d = abtt_pkg::ST_IDLE;
          endcase
        end
      end

      abtt_pkg::ST_INSERT: begin
        state_d      = abtt_pkg::ST_FINISH;
        pend_valid_d = 1'b1;
        priority if (!valid_q[1]) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(1);
          vset      = 1'b1;
          vset_idx  = IW'(1);
          pend_d    = abtt_pkg::plain_item(abtt_pkg::STAT_OK, SW'(1));
        end else if (!p_in_range) begin
          pend_d = abtt_pkg::plain_item(abtt_pkg::STAT_OUT_OF_RANGE, '0);
        end else if (!valid_q[p_idx]) begin
          pend_d = abtt_pkg::plain_item(abtt_pkg::STAT_PARENT_EMPTY, '0);
        end else if (c_w >= (IW + 1)'(TABLE_SIZE)) begin
          pend_d = abtt_pkg::plain_item(abtt_pkg::STAT_OUT_OF_RANGE, '0);
        end else if (valid_q[c_w[IW-1:0]]) begin
          pend_d = abtt_pkg::plain_item(abtt_pkg::STAT_OCCUPIED, SW'(c_w));
        end else begin
          ram_we    = 1'b1;
          ram_waddr = c_w[IW-1:0];
          vset      = 1'b1;
          vset_idx  = c_w[IW-1:0];
          pend_d    = abtt_pkg::plain_item(abtt_pkg::STAT_OK, SW'(c_w));
        end
      end

      // skip empty slots, read occupied ones
      abtt_pkg::ST_SCAN_RD: begin
        ram_raddr = idx_q;
        if (valid_q[idx_q]) begin
          state_d = abtt_pkg::ST_SCAN_CMP;
        end else if (scan_end) begin
          state_d = abtt_pkg::ST_FINISH;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      abtt_pkg::ST_SCAN_CMP: begin
        if (!key_hit) begin
          if (scan_end) begin
            state_d = abtt_pkg::ST_FINISH;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = abtt_pkg::ST_SCAN_RD;
          end
        end else begin
          unique case (req_q)
            abtt_pkg::REQ_FIND_PARENT: begin
              ram_raddr = up_idx;
              state_d   = abtt_pkg::ST_PAR_DATA;
            end
            abtt_pkg::REQ_FIND_CHILDREN: begin
              ram_raddr = left_w[IW-1:0];
              state_d   = abtt_pkg::ST_KID_LEFT;
            end
            abtt_pkg::REQ_DELETE: begin
              if (!left_occ && !right_occ) begin
                vclr         = 1'b1;
                vclr_idx     = idx_q;
                pend_d       = new_item;
                pend_valid_d = 1'b1;
                state_d      = abtt_pkg::ST_FINISH;
              end else begin
                sidx_d  = IW'(SLast);
                state_d = abtt_pkg::ST_DEL_FIND;
              end
            end
            default: begin
              pend_d       = new_item;
              pend_valid_d = 1'b1;
              state_d      = abtt_pkg::ST_FINISH;
            end
          endcase
        end
      end

      // fetch the parent value, then hand the beat on
      abtt_pkg::ST_PAR_DATA: begin
        ram_raddr               = up_idx;
        new_item.parent_present = valid_q[up_idx];
        new_item.parent_value   = valid_q[up_idx] ? OW'(ram_rdata) : '0;
        if (can_push) begin
          out_load     = pend_valid_q;
          pend_d       = new_item;
          pend_valid_d = 1'b1;
          n_d          = n_q + SW'(1);
          if (scan_end || n_q == SW'(abtt_pkg::MaxRes - 1)) begin
            state_d = abtt_pkg::ST_FINISH;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = abtt_pkg::ST_SCAN_RD;
          end
        end
      end

      // keep the left child value, read the right one
      abtt_pkg::ST_KID_LEFT: begin
        lval_d    = left_occ ? OW'(ram_rdata) : '0;
        ram_raddr = right_w[IW-1:0];
        state_d   = abtt_pkg::ST_KID_RIGHT;
      end

      abtt_pkg::ST_KID_RIGHT: begin
        ram_raddr              = right_w[IW-1:0];
        new_item.left_present  = left_occ;
        new_item.left_value    = lval_q;
        new_item.right_present = right_occ;
        new_item.right_value   = right_occ ? OW'(ram_rdata) : '0;
        if (can_push) begin
          out_load     = pend_valid_q;
          pend_d       = new_item;
          pend_valid_d = 1'b1;
          n_d          = n_q + SW'(1);
          if (scan_end || n_q == SW'(abtt_pkg::MaxRes - 1)) begin
            state_d = abtt_pkg::ST_FINISH;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = abtt_pkg::ST_SCAN_RD;
          end
        end
      end

      // walk odd slots downwards for the highest occupied one
      abtt_pkg::ST_DEL_FIND: begin
        ram_raddr = sidx_q;
        if (valid_q[sidx_q]) begin
          state_d = abtt_pkg::ST_DEL_WR;
        end else if (sidx_q == IW'(3)) begin
          pend_d       = new_item;
          pend_valid_d = 1'b1;
          state_d      = abtt_pkg::ST_FINISH;
        end else begin
          sidx_d = sidx_q - IW'(2);
        end
      end

      // move the value across and drop the source slot
      abtt_pkg::ST_DEL_WR: begin
        ram_we       = 1'b1;
        ram_waddr    = idx_q;
        ram_wdata    = ram_rdata;
        vclr         = 1'b1;
        vclr_idx     = sidx_q;
        pend_d       = new_item;
        pend_valid_d = 1'b1;
        state_d      = abtt_pkg::ST_FINISH;
      end

      // hand over the final beat, or not found when nothing matched
      abtt_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_d   = 1'b1;
          out_item_d   = pend_valid_q ? pend_q :
                         abtt_pkg::plain_item(abtt_pkg::STAT_NOT_FOUND, '0);
          pend_valid_d = 1'b0;
          state_d      = abtt_pkg::ST_IDLE;
        end
      end

      default: state_d = abtt_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= abtt_pkg::ST_IDLE;
      idx_q        <= '0;
      sidx_q       <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      sidx_q       <= sidx_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
      if (vset) begin
        valid_q[vset_idx] <= 1'b1;
      end
      if (vclr) begin
        valid_q[vclr_idx] <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q   <= abtt_pkg::req_e'(req_type_i);
      key_q   <= VW'(key_value_i);
      pslot_q <= parent_slot_i;
      side_q  <= child_side_i;
    end
    pend_q <= pend_d;
    lval_q <= lval_d;
    if (out_load) begin
      out_item_q <= out_item_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_item_q.status;
  assign node_slot_o      = out_item_q.node_slot;
  assign parent_value_o   = out_item_q.parent_value;
  assign parent_present_o = out_item_q.parent_present;
  assign left_value_o     = out_item_q.left_value;
  assign left_present_o   = out_item_q.left_present;
  assign right_value_o    = out_item_q.right_value;
  assign right_present_o  = out_item_q.right_present;
  assign last_result_o    = out_last_q;

endmodule

// ===== rtl/abtt_checker.sv =====
module abtt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [2:0]         req_type_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         status_o,
  input logic signed [31:0] parent_value_o,
  input logic               parent_present_o,
  input logic signed [31:0] left_value_o,
  input logic               left_present_o,
  input logic signed [31:0] right_value_o,
  input logic               right_present_o,
  input logic               last_result_o
);

  // a stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a known request keeps the input side stalled while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i <= 3'(abtt_pkg::REQ_FIND_INDEX)) |=> in_stall_o)
    else $error("input taken again while a request is in flight");

  // any failure status closes the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != 3'(abtt_pkg::STAT_OK)) |-> last_result_o)
    else $error("failure beat not marked last");

  // an absent neighbour reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (parent_present_o || parent_value_o == 32'sd0) &&
                    (left_present_o || left_value_o == 32'sd0) &&
                    (right_present_o || right_value_o == 32'sd0))
    else $error("absent neighbour carries a value");

endmodule

bind array_binary_tree_table_unit abtt_checker u_abtt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .req_type_i      (req_type_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .parent_value_o  (parent_value_o),
  .parent_present_o(parent_present_o),
  .left_value_o    (left_value_o),
  .left_present_o  (left_present_o),
  .right_value_o   (right_value_o),
  .right_present_o (right_present_o),
  .last_result_o   (last_result_o)
);

// ===== dv/tb_array_binary_tree_table_unit.sv =====
`timescale 1ns / 100ps

module tb_array_binary_tree_table_unit;

  localparam int Slots       = 64;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 200;
  localparam int ScriptLen   = 25;

  // Request codes the block leaves unused
  localparam logic [2:0] ReqUnusedLo = 3'd5;
  localparam logic [2:0] ReqUnusedHi = 3'd7;

  typedef struct {
    abtt_pkg::item_t it;
    logic            last;
  } beat_t;

  typedef struct packed {
    logic [2:0]        req;
    logic [31:0]       key;
    logic [5:0]        par;
    logic              side;
    logic              typed;
    abtt_pkg::status_e st;
    logic [5:0]        slot;
  } row_t;

  // Directed requests; typed rows carry their one expected beat, the rest use the predictor
  localparam row_t Script [ScriptLen] = '{
    '{abtt_pkg::REQ_FIND_INDEX,    32'd5,         6'd0,  1'b0, 1'b1,
      abtt_pkg::STAT_NOT_FOUND,    6'd0},
    '{abtt_pkg::REQ_DELETE,        32'd5,         6'd0,  1'b0, 1'b1,
      abtt_pkg::STAT_NOT_FOUND,    6'd0},
    '{abtt_pkg::REQ_INSERT,        32'h7fff_ffff, 6'd0,  1'b0, 1'b1,
      abtt_pkg::STAT_OK,           6'd1},
    '{abtt_pkg::REQ_INSERT,        32'h8000_0000, 6'd1,  1'b0, 1'b1,
      abtt_pkg::STAT_OK,           6'd2},
    '{abtt_pkg::REQ_INSERT,        32'hffff_ffff, 6'd1,  1'b1, 1'b1,
      abtt_pkg::STAT_OK,           6'd3},
    '{abtt_pkg::REQ_INSERT,        32'h0,         6'd1,  1'b1, 1'b1,
      abtt_pkg::STAT_OCCUPIED,     6'd3},
    '{abtt_pkg::REQ_INSERT,        32'h0,         6'd63, 1'b1, 1'b1,
      abtt_pkg::STAT_PARENT_EMPTY, 6'd0},
    '{abtt_pkg::REQ_INSERT,        32'h0,         6'd3,  1'b1, 1'b1,
      abtt_pkg::STAT_OK,           6'd7},
    '{abtt_pkg::REQ_INSERT,        32'hffff_ffff, 6'd7,  1'b1, 1'b1,
      abtt_pkg::STAT_OK,           6'd15},
    '{abtt_pkg::REQ_INSERT,        32'h1,         6'd15, 1'b1, 1'b1,
      abtt_pkg::STAT_OK,           6'd31},
    '{abtt_pkg::REQ_INSERT,        32'h7fff_ffff, 6'd31, 1'b1, 1'b1,
      abtt_pkg::STAT_OK,           6'd63},
    '{abtt_pkg::REQ_INSERT,        32'h2,         6'd63, 1'b0, 1'b1,
      abtt_pkg::STAT_OUT_OF_RANGE, 6'd0},
    // root has no parent; slot 63 has its children outside the table
    '{abtt_pkg::REQ_FIND_PARENT,   32'h7fff_ffff, 6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    '{abtt_pkg::REQ_FIND_CHILDREN, 32'hffff_ffff, 6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    '{abtt_pkg::REQ_FIND_CHILDREN, 32'h7fff_ffff, 6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    '{ReqUnusedHi,                 32'hffff_ffff, 6'd63, 1'b1, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    // inner node, leaf, inner nodes pulling from the highest odd slot, then a leaf
    '{abtt_pkg::REQ_DELETE,        32'h0,         6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    '{abtt_pkg::REQ_DELETE,        32'h1,         6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    '{abtt_pkg::REQ_DELETE,        32'hffff_ffff, 6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    '{abtt_pkg::REQ_DELETE,        32'h7fff_ffff, 6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    '{abtt_pkg::REQ_DELETE,        32'hffff_ffff, 6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    // root with only a left child: no odd slot to pull from
    '{abtt_pkg::REQ_DELETE,        32'h7fff_ffff, 6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0},
    '{abtt_pkg::REQ_INSERT,        32'h5,         6'd2,  1'b1, 1'b1,
      abtt_pkg::STAT_OK,           6'd5},
    '{abtt_pkg::REQ_INSERT,        32'h6,         6'd5,  1'b0, 1'b1,
      abtt_pkg::STAT_OK,           6'd10},
    // slot 5 is itself the highest odd slot and ends up empty
    '{abtt_pkg::REQ_DELETE,        32'h5,         6'd0,  1'b0, 1'b0,
      abtt_pkg::STAT_OK,           6'd0}
  };

  localparam logic [31:0] KeyPool [8] = '{
    32'h0, 32'h1, 32'h2, 32'h3, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h5555_aaaa
  };

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic [2:0]         req_type_i       = '0;
  logic signed [31:0] key_value_i      = '0;
  logic [5:0]         parent_slot_i    = '0;
  logic               child_side_i     = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [2:0]         status_o;
  logic [5:0]         node_slot_o;
  logic signed [31:0] parent_value_o;
  logic               parent_present_o;
  logic signed [31:0] left_value_o;
  logic               left_present_o;
  logic signed [31:0] right_value_o;
  logic               right_present_o;
  logic               last_result_o;

  logic [31:0] tree_val [Slots];
  bit          tree_vld [Slots];
  beat_t       fresh_beats [$];
  beat_t       awaited_beats [$];
  int          err_cnt        = 0;
  int          cycles         = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  array_binary_tree_table_unit u_top (.*);

  always #4 clk_i = ~clk_i;

  function automatic bit slot_held(int s);
    return s < Slots && tree_vld[s];
  endfunction

  function automatic logic [31:0] held_value(int s);
    return slot_held(s) ? tree_val[s] : '0;
  endfunction

  function automatic int lowest_match(logic [31:0] key);
    for (int i = 1; i < Slots; i++)
      if (tree_vld[i] && tree_val[i] == key) return i;
    return 0;
  endfunction

  function automatic void add_beat(abtt_pkg::status_e st, int slot, logic [31:0] pv, bit pp,
                                   logic [31:0] lv, bit lp, logic [31:0] rv, bit rp,
                                   bit last);
    beat_t b;
    b.it.status         = st;
    b.it.node_slot      = slot[5:0];
    b.it.parent_value   = pv;
    b.it.parent_present = pp;
    b.it.left_value     = lv;
    b.it.left_present   = lp;
    b.it.right_value    = rv;
    b.it.right_present  = rp;
    b.last              = last;
    fresh_beats.push_back(b);
  endfunction

  // Apply one request to the tree copy and collect the beats it answers with
  function automatic void tree_request(logic [2:0] req, logic [31:0] key, logic [5:0] par,
                                       logic side);
    int c;
    int m;
    int n;
    int s;
    fresh_beats.delete();
    case (req)
      abtt_pkg::REQ_INSERT: begin
        c = 2 * par + side;
        if (!tree_vld[1]) begin
          tree_val[1] = key;
          tree_vld[1] = 1'b1;
          add_beat(abtt_pkg::STAT_OK, 1, '0, 0, '0, 0, '0, 0, 1);
        end else if (!tree_vld[par]) begin
          add_beat(abtt_pkg::STAT_PARENT_EMPTY, 0, '0, 0, '0, 0, '0, 0, 1);
        end else if (c >= Slots) begin
          add_beat(abtt_pkg::STAT_OUT_OF_RANGE, 0, '0, 0, '0, 0, '0, 0, 1);
        end else if (tree_vld[c]) begin
          add_beat(abtt_pkg::STAT_OCCUPIED, c, '0, 0, '0, 0, '0, 0, 1);
        end else begin
          tree_val[c] = key;
          tree_vld[c] = 1'b1;
          add_beat(abtt_pkg::STAT_OK, c, '0, 0, '0, 0, '0, 0, 1);
        end
      end
      abtt_pkg::REQ_DELETE, abtt_pkg::REQ_FIND_INDEX: begin
        m = lowest_match(key);
        if (m == 0) begin
          add_beat(abtt_pkg::STAT_NOT_FOUND, 0, '0, 0, '0, 0, '0, 0, 1);
        end else begin
          if (req == abtt_pkg::REQ_DELETE) begin
            if (!slot_held(2 * m) && !slot_held(2 * m + 1)) begin
              tree_vld[m] = 1'b0;
            end else begin
              // pull the value of the highest occupied odd slot into the node
              s = Slots - 1;
              if (s % 2 == 0) s--;
              while (s >= 3 && !tree_vld[s]) s -= 2;
              if (s >= 3) begin
                tree_val[m] = tree_val[s];
                tree_vld[s] = 1'b0;
              end
            end
          end
          add_beat(abtt_pkg::STAT_OK, m, '0, 0, '0, 0, '0, 0, 1);
        end
      end
      abtt_pkg::REQ_FIND_PARENT, abtt_pkg::REQ_FIND_CHILDREN: begin
        n = 0;
        for (int i = 1; i < Slots && n < abtt_pkg::MaxRes; i++) begin
          if (tree_vld[i] && tree_val[i] == key) begin
            if (req == abtt_pkg::REQ_FIND_PARENT)
              add_beat(abtt_pkg::STAT_OK, i, held_value(i / 2), slot_held(i / 2),
                       '0, 0, '0, 0, 0);
            else
              add_beat(abtt_pkg::STAT_OK, i, '0, 0, held_value(2 * i), slot_held(2 * i),
                       held_value(2 * i + 1), slot_held(2 * i + 1), 0);
            n++;
          end
        end
        if (n == 0) add_beat(abtt_pkg::STAT_NOT_FOUND, 0, '0, 0, '0, 0, '0, 0, 1);
        else fresh_beats[fresh_beats.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Drive one request beat, hold it through stalls, then book its results
  task automatic send_req(logic [2:0] req, logic [31:0] key, logic [5:0] par, logic side,
                          bit typed = 1'b0, abtt_pkg::status_e st = abtt_pkg::STAT_OK,
                          logic [5:0] slot = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    key_value_i   <= key;
    parent_slot_i <= par;
    child_side_i  <= side;
    do @(posedge clk_i); while (in_stall_o);
    tree_request(req, key, par, side);
    if (typed) begin
      fresh_beats.delete();
      add_beat(st, slot, '0, 0, '0, 0, '0, 0, 1);
    end
    foreach (fresh_beats[k]) awaited_beats.push_back(fresh_beats[k]);
  endtask

  function automatic int some_held_slot();
    int s;
    for (int k = 0; k < 8; k++) begin
      s = $urandom_range(Slots - 1, 1);
      if (tree_vld[s]) return s;
    end
    return 1;
  endfunction

  // Favour values already in the tree so searches and deletes hit
  function automatic logic [31:0] pick_key();
    int r;
    int s;
    r = $urandom_range(9);
    s = some_held_slot();
    if (r < 5 && tree_vld[s]) return tree_val[s];
    if (r < 8) return KeyPool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic random_reqs(int count);
    logic [2:0]  req;
    logic [31:0] key;
    logic [5:0]  par;
    logic        side;
    int          r;
    repeat (count) begin
      r    = $urandom_range(99);
      key  = pick_key();
      par  = 6'($urandom_range(63));
      side = 1'($urandom_range(1));
      if (r < 35) begin
        req = abtt_pkg::REQ_INSERT;
        if ($urandom_range(9) < 8) par = 6'(some_held_slot());
      end else if (r < 55) begin
        req = abtt_pkg::REQ_DELETE;
      end else if (r < 70) begin
        req = abtt_pkg::REQ_FIND_PARENT;
      end else if (r < 85) begin
        req = abtt_pkg::REQ_FIND_CHILDREN;
      end else if (r < 95) begin
        req = abtt_pkg::REQ_FIND_INDEX;
      end else begin
        req = 3'($urandom_range(ReqUnusedHi, ReqUnusedLo));
      end
      send_req(req, key, par, side);
    end
  endtask

  // Empty the table, fill every slot with one key, then ask for all matches at once
  task automatic full_tree_pass();
    logic [31:0] fill_key;
    int          top;
    for (int k = 0; k < 2 * Slots; k++) begin
      top = 0;
      for (int s = 1; s < Slots; s++)
        if (tree_vld[s]) top = s;
      if (top == 0) break;
      send_req(abtt_pkg::REQ_DELETE, tree_val[top], 6'($urandom_range(63)),
               1'($urandom_range(1)));
    end
    fill_key = $urandom;
    send_req(abtt_pkg::REQ_INSERT, fill_key, '0, 1'b0);
    for (int c = 2; c < Slots; c++)
      send_req(abtt_pkg::REQ_INSERT, fill_key, 6'(c / 2), 1'(c % 2));
    send_req(abtt_pkg::REQ_FIND_PARENT, fill_key, 6'($urandom_range(63)),
             1'($urandom_range(1)));
    send_req(abtt_pkg::REQ_FIND_CHILDREN, fill_key, 6'($urandom_range(63)),
             1'($urandom_range(1)));
  endtask

  // Stall the result channel at random
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result beat with the oldest one awaited
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_beats.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with none awaited, expected nothing, got status %0d slot %0d",
                 $time, status_o, node_slot_o);
      end else begin
        want = awaited_beats.pop_front();
        check_field("status", want.it.status, status_o);
        check_field("node_slot", want.it.node_slot, node_slot_o);
        check_field("parent_value", want.it.parent_value, parent_value_o);
        check_field("parent_present", want.it.parent_present, parent_present_o);
        check_field("left_value", want.it.left_value, left_value_o);
        check_field("left_present", want.it.left_present, left_present_o);
        check_field("right_value", want.it.right_value, right_value_o);
        check_field("right_present", want.it.right_present, right_present_o);
        check_field("last_result", want.last, last_result_o);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_array_binary_tree_table_unit: done, errors");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < Slots; s++) begin
      tree_val[s] = '0;
      tree_vld[s] = 1'b0;
    end
    send_idle_pct  = 14;
    recv_stall_pct = 74;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int k = 0; k < ScriptLen; k++)
      send_req(Script[k].req, Script[k].key, Script[k].par, Script[k].side,
               Script[k].typed, Script[k].st, Script[k].slot);
    random_reqs(30);

    send_idle_pct  = 74;
    recv_stall_pct = 14;
    random_reqs(30);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    full_tree_pass();
    random_reqs(10);

    // drop valid and let the last results drain
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0 && awaited_beats.size() == 0) begin
      $display("tb_array_binary_tree_table_unit: done, clean");
    end else begin
      $display("tb_array_binary_tree_table_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/abtt_pkg.sv
rtl/abtt_ram.sv
rtl/array_binary_tree_table_unit.sv
rtl/abtt_checker.sv
dv/tb_array_binary_tree_table_unit.sv
